// File: sv/usb_srh_pkg.sv
package usb_srh_pkg;

  // number of string descriptor slots, slot 0 is the language table
  localparam int unsigned StringCount = 4;

  // result outcome codes
  typedef enum logic [1:0] {
    OUTCOME_HANDLED = 2'd0,
    OUTCOME_STALL   = 2'd1,
    OUTCOME_VENDOR  = 2'd2
  } outcome_e;

  // descriptor kinds
  localparam logic [1:0] DescDevice = 2'd0;
  localparam logic [1:0] DescConfig = 2'd1;
  localparam logic [1:0] DescString = 2'd2;

  // descriptor type in the high byte of wValue
  localparam logic [7:0] DtDevice = 8'h01;
  localparam logic [7:0] DtConfig = 8'h02;
  localparam logic [7:0] DtString = 8'h03;

  // standard request codes
  localparam logic [7:0] ReqGetStatus     = 8'd0;
  localparam logic [7:0] ReqClearFeature  = 8'd1;
  localparam logic [7:0] ReqReserved2     = 8'd2;
  localparam logic [7:0] ReqSetFeature    = 8'd3;
  localparam logic [7:0] ReqReserved4     = 8'd4;
  localparam logic [7:0] ReqSetAddress    = 8'd5;
  localparam logic [7:0] ReqGetDescriptor = 8'd6;
  localparam logic [7:0] ReqSetDescriptor = 8'd7;
  localparam logic [7:0] ReqGetConfig     = 8'd8;
  localparam logic [7:0] ReqSetConfig     = 8'd9;
  localparam logic [7:0] ReqGetInterface  = 8'd10;
  localparam logic [7:0] ReqSetInterface  = 8'd11;
  localparam logic [7:0] ReqSynchFrame    = 8'd12;

  // bmRequestType values
  localparam logic [7:0] RtHostDevice   = 8'h00;
  localparam logic [7:0] RtHostEndpoint = 8'h02;
  localparam logic [7:0] RtDevDevice    = 8'h80;
  localparam logic [7:0] RtDevInterface = 8'h81;
  localparam logic [7:0] RtDevEndpoint  = 8'h82;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_DATA_ENDPOINT    = 2'd0,
    CFG_CONFIG_VALUE     = 2'd1,
    CFG_INTERFACE_NUMBER = 2'd2,
    CFG_LANGUAGE_ID      = 2'd3
  } cfg_index_e;

  // one decoded result
  typedef struct packed {
    outcome_e   outcome;
    logic [1:0] reply_length;
    logic [7:0] reply_byte;
    logic       descriptor_valid;
    logic [1:0] descriptor_kind;
    logic [1:0] string_slot;
    logic       toggle_reset;
  } result_t;

endpackage

// File: sv/usb_standard_request_handler_top.sv
// usb standard request handler
//
// input channel: one setup packet per item (bmRequestType, bRequest, wValue,
// wIndex), taken at a clock edge where in_valid_i is high and in_stall_o low.
// output channel: one result item per setup packet, in order, taken at an
// edge where out_valid_o is high and out_stall_i low.
// configuration: cfg_valid_i with cfg_index_i / cfg_data_i, always ready;
// write only while no item is in flight.
//
// an item is held in the input register, is decoded against the halt bits and
// lands in the result register. throughput is one item per clock while the
// receiver does not stall; the rate is set by the single decode stage between
// the two registers, which also updates the halt bits.
// when the receiver stalls, the result register holds and the input register
// fills; in_stall_o rises only once both are occupied and the result is stalled.
// reset clears both valid flags and all halt bits and loads the register
// defaults (data endpoint 2, configuration 1, interface 0, language 0x0409).
module usb_standard_request_handler_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // setup packet in
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  request_type_i,
  input  logic [7:0]  request_code_i,
  input  logic [15:0] value_word_i,
  input  logic [15:0] index_word_i,
  // result out
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  outcome_o,
  output logic [1:0]  reply_length_o,
  output logic [7:0]  reply_byte_o,
  output logic        descriptor_valid_o,
  output logic [1:0]  descriptor_kind_o,
  output logic [1:0]  string_slot_o,
  output logic        toggle_reset_o,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import usb_srh_pkg::*;

  // configuration registers
  logic [2:0]  data_ep_q;
  logic [7:0]  config_value_q;
  logic [7:0]  interface_num_q;
  logic [15:0] language_id_q;

  // halt bookkeeping, bit n-1 belongs to endpoint n
  logic       ep0_halt_q, ep0_halt_d;
  logic [6:0] in_halt_q, in_halt_d;
  logic [6:0] out_halt_q, out_halt_d;

  // input register
  logic        s1_valid_q;
  logic [7:0]  rtype_q;
  logic [7:0]  code_q;
  logic [15:0] wvalue_q;
  logic [15:0] windex_q;

  // result register
  logic    out_valid_q;
  result_t res_q, res_d;

  logic in_accept;
  logic s2_free;
  logic s1_move;

  // endpoint decode
  logic       ep_ok;
  logic [2:0] ep_num;
  logic       ep_dir_in;
  logic [7:0] in_vec, out_vec, in_vec_w, out_vec_w;
  logic       halt_bit;
  logic       do_write;
  logic       write_set;

  assign cfg_ready_o = 1'b1;

  // the result register frees up when empty or being taken this cycle
  assign s2_free    = !out_valid_q || !out_stall_i;
  assign s1_move    = s1_valid_q && s2_free;
  assign in_stall_o = s1_valid_q && !s2_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_ep_q       <= 3'd2;
      config_value_q  <= 8'd1;
      interface_num_q <= 8'd0;
      language_id_q   <= 16'd1033;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_DATA_ENDPOINT:    data_ep_q       <= cfg_data_i[2:0];
        CFG_CONFIG_VALUE:     config_value_q  <= cfg_data_i[7:0];
        CFG_INTERFACE_NUMBER: interface_num_q <= cfg_data_i[7:0];
        CFG_LANGUAGE_ID:      language_id_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // endpoint address from the low byte of wIndex, numbers 8 to 15 invalid
  assign ep_ok     = !windex_q[3];
  assign ep_num    = windex_q[2:0];
  assign ep_dir_in = windex_q[7];

  // endpoint 0 shares one halt bit for both directions
  assign in_vec   = {in_halt_q, ep0_halt_q};
  assign out_vec  = {out_halt_q, ep0_halt_q};
  assign halt_bit = ep_dir_in ? in_vec[ep_num] : out_vec[ep_num];

  always_comb begin
    res_d            = '0;
    res_d.outcome    = OUTCOME_HANDLED;
    do_write         = 1'b0;
    write_set        = 1'b0;
    ep0_halt_d       = ep0_halt_q;
    in_halt_d        = in_halt_q;
    out_halt_d       = out_halt_q;
    in_vec_w         = in_vec;
    out_vec_w        = out_vec;

    unique case (code_q) inside
      ReqGetStatus: begin
        if (rtype_q == RtDevDevice || rtype_q == RtDevInterface) begin
          res_d.reply_length = 2'd2;
        end else if (rtype_q == RtDevEndpoint && ep_ok) begin
          res_d.reply_length = 2'd2;
          res_d.reply_byte   = {7'd0, halt_bit};
        end else begin
          res_d.outcome = OUTCOME_STALL;
        end
      end
      ReqClearFeature, ReqSetFeature: begin
        if (rtype_q == RtHostDevice && code_q == ReqClearFeature) begin
          res_d.outcome = OUTCOME_STALL;
        end else if (rtype_q == RtHostEndpoint) begin
          if (wvalue_q != 16'd0 || !ep_ok) begin
            res_d.outcome = OUTCOME_STALL;
          end else begin
            do_write  = 1'b1;
            write_set = (code_q == ReqSetFeature);
          end
        end
      end
      ReqGetDescriptor: begin
        unique case (wvalue_q[15:8]) inside
          DtDevice: begin
            res_d.descriptor_valid = 1'b1;
            res_d.descriptor_kind  = DescDevice;
          end
          DtConfig: begin
            res_d.descriptor_valid = 1'b1;
            res_d.descriptor_kind  = DescConfig;
          end
          DtString: begin
            if (windex_q == language_id_q) begin
              if (32'(wvalue_q[7:0]) >= StringCount) begin
                res_d.outcome = OUTCOME_STALL;
              end else begin
                res_d.descriptor_valid = 1'b1;
                res_d.descriptor_kind  = DescString;
                res_d.string_slot      = wvalue_q[1:0];
              end
            end else if (windex_q == 16'd0) begin
              res_d.descriptor_valid = 1'b1;
              res_d.descriptor_kind  = DescString;
            end else begin
              res_d.outcome = OUTCOME_STALL;
            end
          end
          default: res_d.outcome = OUTCOME_STALL;
        endcase
      end
      ReqGetConfig: begin
        res_d.reply_length = 2'd1;
        res_d.reply_byte   = config_value_q;
      end
      ReqGetInterface: begin
        res_d.reply_length = 2'd1;
        res_d.reply_byte   = interface_num_q;
      end
      ReqSetInterface: begin
        res_d.toggle_reset = 1'b1;
        // data endpoint 0 leaves the halt bits alone
        if (data_ep_q != 3'd0) begin
          in_vec_w[data_ep_q]  = 1'b0;
          out_vec_w[data_ep_q] = 1'b0;
          in_halt_d            = in_vec_w[7:1];
          out_halt_d           = out_vec_w[7:1];
        end
      end
      ReqSetAddress, ReqSetConfig, ReqSynchFrame: ;
      ReqReserved2, ReqReserved4, ReqSetDescriptor: res_d.outcome = OUTCOME_STALL;
      default: res_d.outcome = OUTCOME_VENDOR;
    endcase

    if (do_write) begin
      if (ep_num == 3'd0) begin
        ep0_halt_d = write_set;
      end else if (ep_dir_in) begin
        in_vec_w[ep_num] = write_set;
        in_halt_d        = in_vec_w[7:1];
      end else begin
        out_vec_w[ep_num] = write_set;
        out_halt_d        = out_vec_w[7:1];
      end
    end
  end

  // halt bits change only as an item passes into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ep0_halt_q <= 1'b0;
      in_halt_q  <= '0;
      out_halt_q <= '0;
    end else if (s1_move) begin
      ep0_halt_q <= ep0_halt_d;
      in_halt_q  <= in_halt_d;
      out_halt_q <= out_halt_d;
    end
  end

  // pipeline valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_accept || (s1_valid_q && !s2_free);
      if (s2_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      rtype_q  <= request_type_i;
      code_q   <= request_code_i;
      wvalue_q <= value_word_i;
      windex_q <= index_word_i;
    end
    if (s1_move) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign outcome_o          = res_q.outcome;
  assign reply_length_o     = res_q.reply_length;
  assign reply_byte_o       = res_q.reply_byte;
  assign descriptor_valid_o = res_q.descriptor_valid;
  assign descriptor_kind_o  = res_q.descriptor_kind;
  assign string_slot_o      = res_q.string_slot;
  assign toggle_reset_o     = res_q.toggle_reset;

  // halt bits stay put unless an item is decoded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_move |=> ($stable(in_halt_q) && $stable(out_halt_q) && $stable(ep0_halt_q)))
    else $error("halt bits changed with no item decoded");

  // input side stalls only when both registers are occupied
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled with room in the pipeline");

  // a decoded item reaches the result register on the next edge
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_move |=> out_valid_q)
    else $error("decoded item lost");

  // a selected descriptor or toggle reset only comes with a handled outcome
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (res_q.descriptor_valid || res_q.toggle_reset))
      |-> (res_q.outcome == OUTCOME_HANDLED && res_q.reply_length == 2'd0))
    else $error("descriptor or toggle reset on a refused request");

endmodule
